// ----- src/nlr_pkg.sv -----
// ----------------------------------------------------------------------------
// nlr_pkg: shared definitions for the numeric literal recognizer
// Character constants, result codes, the classified character word that
// travels from the front to the back, and the length saturation helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package nlr_pkg;

	// Length limit and the width of the internal character counter.
	localparam int MAX_LEN = 255;
	localparam int CNT_W   = $clog2(MAX_LEN + 1);
	localparam int LEN_W   = (CNT_W > 8) ? CNT_W : 8;

	// Queue between the front and the back.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef logic [CNT_W-1:0] cnt_t;

	// Characters that the recognizer tests for.
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_1     = 8'h31;
	localparam logic [7:0] CH_7     = 8'h37;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_LC_A  = 8'h61;
	localparam logic [7:0] CH_LC_F  = 8'h66;
	localparam logic [7:0] CH_UC_A  = 8'h41;
	localparam logic [7:0] CH_UC_F  = 8'h46;
	localparam logic [7:0] CH_LC_X  = 8'h78;
	localparam logic [7:0] CH_UC_X  = 8'h58;
	localparam logic [7:0] CH_LC_O  = 8'h6f;
	localparam logic [7:0] CH_UC_O  = 8'h4f;
	localparam logic [7:0] CH_LC_B  = 8'h62;
	localparam logic [7:0] CH_UC_B  = 8'h42;
	localparam logic [7:0] CH_LC_E  = 8'h65;
	localparam logic [7:0] CH_UC_E  = 8'h45;
	localparam logic [7:0] CH_LC_P  = 8'h70;
	localparam logic [7:0] CH_UC_P  = 8'h50;
	localparam logic [7:0] CH_US    = 8'h5f;
	localparam logic [7:0] CH_DOT   = 8'h2e;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;

	// Result kinds.
	localparam logic [2:0] KIND_DEC   = 3'd0;
	localparam logic [2:0] KIND_FLOAT = 3'd4;

	// Error codes.
	localparam logic [2:0] ERR_NONE   = 3'd0;
	localparam logic [2:0] ERR_DIGIT  = 3'd1;
	localparam logic [2:0] ERR_USCORE = 3'd2;
	localparam logic [2:0] ERR_LZERO  = 3'd3;
	localparam logic [2:0] ERR_BOFLT  = 3'd4;

	// Pushback counts.
	localparam logic [1:0] PB_NONE = 2'd0;
	localparam logic [1:0] PB_TERM = 2'd1;
	localparam logic [1:0] PB_DOT  = 2'd2;

	typedef enum logic [1:0] {
		BASE_DEC = 2'd0,
		BASE_HEX = 2'd1,
		BASE_OCT = 2'd2,
		BASE_BIN = 2'd3
	} base_t;

	typedef enum logic [3:0] {
		PH_IDLE      = 4'd0,
		PH_ZERO      = 4'd1,
		PH_PREFIX    = 4'd2,
		PH_INT       = 4'd3,
		PH_DOT       = 4'd4,
		PH_FRAC      = 4'd5,
		PH_EXP_START = 4'd6,
		PH_EXP_SIGN  = 4'd7,
		PH_EXP       = 4'd8
	} phase_t;

	// One classified character, as the front hands it to the back.
	typedef struct packed {
		logic start;
		logic is_dec;
		logic is_oct;
		logic is_bin;
		logic is_hex;
		logic is_zero;
		logic is_us;
		logic is_dot;
		logic is_e;
		logic is_p;
		logic is_x;
		logic is_o;
		logic is_b;
		logic is_sign;
	} item_t;

	// Saturating add of a small increment to the character counter.
	function automatic cnt_t sat_add(cnt_t a, logic [1:0] b);
		logic [CNT_W:0] s;
		s = {1'b0, a} + (CNT_W + 1)'(b);
		if (s > (CNT_W + 1)'(MAX_LEN)) begin
			return CNT_W'(MAX_LEN);
		end
		return s[CNT_W-1:0];
	endfunction

	// Reported length is limited to what fits in eight bits.
	function automatic logic [7:0] clip_len(cnt_t a);
		logic [LEN_W-1:0] w;
		w = LEN_W'(a);
		if (w > LEN_W'(255)) begin
			return 8'hff;
		end
		return w[7:0];
	endfunction

endpackage

`default_nettype wire

// ----- src/nlr_front.sv -----
// ----------------------------------------------------------------------------
// nlr_front: character intake and classification
// Accepts one source byte per cycle unless its short queue is full, decodes it
// into character class flags and queues the classified words for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module nlr_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic [7:0]      s_tdata,   // [7:0] ch
	input  logic [0:0]      s_tuser,   // [0] start_req
	output logic            q_valid,
	output nlr_pkg::item_t  q_item,
	input  logic            q_pop
);
	import nlr_pkg::*;

	item_t             cls;
	item_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	logic              pop;
	logic [7:0]        c;

	// Decode the incoming byte into the classes the back end tests.
	always_comb begin
		c           = s_tdata;
		cls.start   = s_tuser[0];
		cls.is_dec  = (c >= CH_0) && (c <= CH_9);
		cls.is_oct  = (c >= CH_0) && (c <= CH_7);
		cls.is_bin  = (c == CH_0) || (c == CH_1);
		cls.is_hex  = cls.is_dec || ((c >= CH_LC_A) && (c <= CH_LC_F))
			|| ((c >= CH_UC_A) && (c <= CH_UC_F));
		cls.is_zero = (c == CH_0);
		cls.is_us   = (c == CH_US);
		cls.is_dot  = (c == CH_DOT);
		cls.is_e    = (c == CH_LC_E) || (c == CH_UC_E);
		cls.is_p    = (c == CH_LC_P) || (c == CH_UC_P);
		cls.is_x    = (c == CH_LC_X) || (c == CH_UC_X);
		cls.is_o    = (c == CH_LC_O) || (c == CH_UC_O);
		cls.is_b    = (c == CH_LC_B) || (c == CH_UC_B);
		cls.is_sign = (c == CH_PLUS) || (c == CH_MINUS);
	end

	assign s_tready = (count_q != QCNT_W'(QDEPTH));
	assign push     = s_tvalid && s_tready;
	assign q_valid  = (count_q != '0);
	assign pop      = q_pop && q_valid;
	assign q_item   = mem_q[rd_ptr_q];

	// Queue storage; entries carry no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= cls;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH))
		else $error("queue fill count exceeds its depth");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count did not grow on a lone push");

	a_pop_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		!pop |=> rd_ptr_q == $past(rd_ptr_q))
		else $error("queue read pointer moved without a pop");

endmodule

`default_nettype wire

// ----- src/nlr_back.sv -----
// ----------------------------------------------------------------------------
// nlr_back: literal state machine and result register
// Takes one classified character per cycle from the queue unless the output
// stalls, steps its state, loads a result word when the literal ends or fails.
// ----------------------------------------------------------------------------
`default_nettype none

module nlr_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  nlr_pkg::item_t  q_item,
	output logic            q_pop,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [15:0]     m_tdata    // [2:0] kind, [5:3] error, [13:6] length,
	                                   // [15:14] pushback
);
	import nlr_pkg::*;

	phase_t     phase_q, nxt_phase;
	base_t      base_q, nxt_base;
	logic       us_q, nxt_us;
	cnt_t       cnt_q, nxt_cnt;
	cnt_t       cnt1, cnt2;
	item_t      it;
	logic       emark;
	logic       dig_ok;
	logic       do_end_int;
	logic       do_fail;
	logic [2:0] fail_err;
	logic       emit;
	logic [2:0] e_kind;
	logic [2:0] e_err;
	cnt_t       e_len;
	logic [1:0] e_pb;

	logic       res_valid_q;
	logic [2:0] res_kind_q;
	logic [2:0] res_err_q;
	logic [7:0] res_len_q;
	logic [1:0] res_pb_q;

	localparam cnt_t CNT_ONE = CNT_W'(1);

	function automatic logic digit_ok(base_t b, item_t x);
		case (b)
			BASE_HEX: return x.is_hex;
			BASE_OCT: return x.is_oct;
			BASE_BIN: return x.is_bin;
			default:  return x.is_dec;
		endcase
	endfunction

	// Take a character whenever the result register is free or draining.
	assign q_pop = q_valid && (!res_valid_q || m_tready);
	assign it    = q_item;

	// Next literal state and result for the character at the queue head.
	always_comb begin
		nxt_phase  = phase_q;
		nxt_base   = base_q;
		nxt_us     = us_q;
		nxt_cnt    = cnt_q;
		emit       = 1'b0;
		e_kind     = KIND_DEC;
		e_err      = ERR_NONE;
		e_len      = cnt_q;
		e_pb       = PB_NONE;
		do_end_int = 1'b0;
		do_fail    = 1'b0;
		fail_err   = ERR_NONE;
		cnt1       = sat_add(cnt_q, 2'd1);
		cnt2       = sat_add(cnt_q, 2'd2);
		emark      = ((base_q == BASE_DEC) && it.is_e) || ((base_q == BASE_HEX) && it.is_p);
		dig_ok     = digit_ok((phase_q == PH_EXP) ? BASE_DEC : base_q, it);

		if (it.start) begin
			nxt_base = BASE_DEC;
			nxt_us   = 1'b0;
			nxt_cnt  = CNT_ONE;
			if (it.is_zero) begin
				nxt_phase = PH_ZERO;
			end else if (it.is_dec) begin
				nxt_phase = PH_INT;
			end else begin
				emit   = 1'b1;
				e_kind = KIND_DEC;
				e_err  = ERR_DIGIT;
				e_len  = CNT_ONE;
			end
		end else begin
			case (phase_q)
				PH_ZERO: begin
					if (it.is_x || it.is_o || it.is_b) begin
						nxt_base  = it.is_x ? BASE_HEX : (it.is_o ? BASE_OCT : BASE_BIN);
						nxt_cnt   = cnt1;
						nxt_phase = PH_PREFIX;
					end else if (it.is_dec) begin
						do_fail  = 1'b1;
						fail_err = ERR_LZERO;
					end else if (it.is_us) begin
						nxt_us    = 1'b1;
						nxt_cnt   = cnt1;
						nxt_phase = PH_INT;
					end else begin
						do_end_int = 1'b1;
					end
				end
				PH_PREFIX: begin
					if (!digit_ok(base_q, it)) begin
						do_fail  = 1'b1;
						fail_err = ERR_DIGIT;
					end else begin
						nxt_cnt   = cnt1;
						nxt_phase = PH_INT;
					end
				end
				PH_INT, PH_FRAC, PH_EXP: begin
					if (it.is_us || dig_ok) begin
						nxt_us  = it.is_us;
						nxt_cnt = cnt1;
					end else if (phase_q == PH_INT) begin
						do_end_int = 1'b1;
					end else if (us_q) begin
						do_fail  = 1'b1;
						fail_err = ERR_USCORE;
					end else if ((phase_q == PH_FRAC) && emark) begin
						nxt_cnt   = cnt1;
						nxt_phase = PH_EXP_START;
					end else if ((base_q == BASE_OCT) || (base_q == BASE_BIN)) begin
						do_fail  = 1'b1;
						fail_err = ERR_BOFLT;
					end else begin
						emit   = 1'b1;
						e_kind = KIND_FLOAT;
						e_len  = cnt_q;
						e_pb   = PB_TERM;
					end
				end
				PH_DOT: begin
					if (digit_ok(base_q, it)) begin
						nxt_cnt   = cnt2;
						nxt_us    = 1'b0;
						nxt_phase = PH_FRAC;
					end else begin
						emit   = 1'b1;
						e_kind = {1'b0, base_q};
						e_len  = cnt_q;
						e_pb   = PB_DOT;
					end
				end
				PH_EXP_START, PH_EXP_SIGN: begin
					if ((phase_q == PH_EXP_START) && it.is_sign) begin
						nxt_cnt   = cnt1;
						nxt_phase = PH_EXP_SIGN;
					end else if (!it.is_dec) begin
						do_fail  = 1'b1;
						fail_err = ERR_DIGIT;
					end else begin
						nxt_cnt   = cnt1;
						nxt_us    = 1'b0;
						nxt_phase = PH_EXP;
					end
				end
				default: begin
					nxt_phase = PH_IDLE;
				end
			endcase
		end

		// End of the integer digit run.
		if (do_end_int) begin
			if (us_q) begin
				do_fail  = 1'b1;
				fail_err = ERR_USCORE;
			end else if (it.is_dot) begin
				nxt_phase = PH_DOT;
			end else if (emark) begin
				nxt_cnt   = cnt1;
				nxt_phase = PH_EXP_START;
			end else begin
				emit   = 1'b1;
				e_kind = {1'b0, base_q};
				e_len  = cnt_q;
				e_pb   = PB_TERM;
			end
		end

		// Errors count the faulting character and push nothing back.
		if (do_fail) begin
			emit   = 1'b1;
			e_kind = {1'b0, base_q};
			e_err  = fail_err;
			e_len  = cnt1;
			e_pb   = PB_NONE;
		end

		if (emit) begin
			nxt_phase = PH_IDLE;
		end
	end

	// Literal state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			base_q  <= BASE_DEC;
			us_q    <= 1'b0;
			cnt_q   <= '0;
		end else if (q_pop) begin
			phase_q <= nxt_phase;
			base_q  <= nxt_base;
			us_q    <= nxt_us;
			cnt_q   <= nxt_cnt;
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (q_pop && emit) begin
			res_valid_q <= 1'b1;
		end else if (m_tready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (q_pop && emit) begin
			res_kind_q <= e_kind;
			res_err_q  <= e_err;
			res_len_q  <= clip_len(e_len);
			res_pb_q   <= e_pb;
		end
	end

	assign m_tvalid = res_valid_q;
	assign m_tdata  = {res_pb_q, res_len_q, res_err_q, res_kind_q};

	a_err_no_pb: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && (res_err_q != ERR_NONE) |-> res_pb_q == PB_NONE)
		else $error("error result carries pushback");

	a_float_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && (res_kind_q == KIND_FLOAT) |->
			(res_err_q == ERR_NONE) && (res_pb_q == PB_TERM))
		else $error("float result with error or wrong pushback");

	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> res_len_q != 8'd0)
		else $error("result with zero length");

endmodule

`default_nettype wire

// ----- src/number_literal_recognizer.sv -----
// ----------------------------------------------------------------------------
// number_literal_recognizer: numeric literal lexer, top level
// Follows numeric literals in a byte stream and reports kind, error,
// length and pushback for each literal that ends or fails.
//
//   channel  | dir | data                                        | side info
//   ---------+-----+---------------------------------------------+--------------
//   s_       | in  | tdata[7:0] ch                               | tuser[0] start_req
//   m_       | out | tdata: [2:0] kind [5:3] error [13:6] length | none
//            |     |        [15:14] pushback                     |
//
// One character word is taken per cycle while the queue has room; the back
// end state machine takes one per cycle unless the output stalls, which sets that rate.
// A result is loaded into the output register when the back end takes the
// character that ends the literal from the queue.
// A four-word queue between the front and the back absorbs output stalls;
// input ready drops only when that queue is full.
// Reset clears the queue, the literal state and the output valid; no
// clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module number_literal_recognizer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] ch
	input  logic [0:0]  s_tuser,   // [0] start_req
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // [2:0] kind, [5:3] error, [13:6] length,
	                               // [15:14] pushback
);
	import nlr_pkg::*;

	logic  q_valid;
	logic  q_pop;
	item_t q_item;

	// Intake, classification and queue.
	nlr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	// Literal state machine and result register.
	nlr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

`default_nettype wire

// ----- sim/nlr_checker.sv -----
// ----------------------------------------------------------------------------
// nlr_checker: scoreboard for the numeric literal recognizer
// Watches both stream channels. Every character word accepted at the input
// is run through a local model of the lexer, which queues the result that
// the literal should produce. Every result word accepted at the output is
// compared field by field with the oldest queued result.
// ----------------------------------------------------------------------------
module nlr_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] ch
	input  logic [0:0]  s_tuser,   // [0] start_req
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,   // [2:0] kind, [5:3] error, [13:6] length,
	                               // [15:14] pushback
	output int          mismatches,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import nlr_pkg::*;

	// Field layout of one result word, lowest field last.
	typedef struct packed {
		logic [1:0] pushback;
		logic [7:0] length;
		logic [2:0] error;
		logic [2:0] kind;
	} lit_result_t;

	// Local copy of the lexer state.
	phase_t      ph = PH_IDLE;
	base_t       nb = BASE_DEC;
	logic        lus = 1'b0;
	int unsigned cnt = 0;

	lit_result_t lit_results[$];
	int          n_bad = 0;
	int          n_wait = 0;

	assign mismatches = n_bad;
	assign pending    = n_wait;

	function automatic logic dec_digit(logic [7:0] c);
		return (c >= CH_0) && (c <= CH_9);
	endfunction

	function automatic logic base_digit(base_t b, logic [7:0] c);
		case (b)
			BASE_HEX: return dec_digit(c) || ((c >= CH_LC_A) && (c <= CH_LC_F)) ||
				((c >= CH_UC_A) && (c <= CH_UC_F));
			BASE_OCT: return (c >= CH_0) && (c <= CH_7);
			BASE_BIN: return (c == CH_0) || (c == CH_1);
			default:  return dec_digit(c);
		endcase
	endfunction

	// Exponent letter: e for decimal, p for hexadecimal, none otherwise.
	function automatic logic exp_letter(base_t b, logic [7:0] c);
		if (b == BASE_DEC) begin
			return (c == CH_LC_E) || (c == CH_UC_E);
		end
		if (b == BASE_HEX) begin
			return (c == CH_LC_P) || (c == CH_UC_P);
		end
		return 1'b0;
	endfunction

	function automatic int unsigned bump(int unsigned a, int unsigned n);
		return (a + n > MAX_LEN) ? MAX_LEN : a + n;
	endfunction

	function automatic lit_result_t pack_result(logic [2:0] k, logic [2:0] e,
			int unsigned len, logic [1:0] pb);
		lit_result_t r;
		r.kind     = k;
		r.error    = e;
		r.length   = (len > 255) ? 8'hff : 8'(len);
		r.pushback = pb;
		return r;
	endfunction

	// An error reports the base so far and counts the faulting character.
	function automatic lit_result_t fault(logic [2:0] e);
		return pack_result({1'b0, nb}, e, bump(cnt, 1), PB_NONE);
	endfunction

	// Advance the model by one character word and queue any result.
	task automatic lex_step(input logic [7:0] c, input logic st);
		lit_result_t r;
		logic        fire;
		logic        int_done;
		base_t       b;
		fire     = 1'b0;
		int_done = 1'b0;
		r        = '0;
		if (st) begin
			nb  = BASE_DEC;
			lus = 1'b0;
			cnt = bump(0, 1);
			if (c == CH_0) begin
				ph = PH_ZERO;
			end else if (dec_digit(c)) begin
				ph = PH_INT;
			end else begin
				r    = pack_result(KIND_DEC, ERR_DIGIT, cnt, PB_NONE);
				fire = 1'b1;
			end
		end else begin
			case (ph)
				PH_ZERO: begin
					if (c == CH_LC_X || c == CH_UC_X) begin
						nb  = BASE_HEX;
						cnt = bump(cnt, 1);
						ph  = PH_PREFIX;
					end else if (c == CH_LC_O || c == CH_UC_O) begin
						nb  = BASE_OCT;
						cnt = bump(cnt, 1);
						ph  = PH_PREFIX;
					end else if (c == CH_LC_B || c == CH_UC_B) begin
						nb  = BASE_BIN;
						cnt = bump(cnt, 1);
						ph  = PH_PREFIX;
					end else if (dec_digit(c)) begin
						r    = fault(ERR_LZERO);
						fire = 1'b1;
					end else if (c == CH_US) begin
						lus = 1'b1;
						cnt = bump(cnt, 1);
						ph  = PH_INT;
					end else begin
						int_done = 1'b1;
					end
				end
				PH_PREFIX: begin
					if (!base_digit(nb, c)) begin
						r    = fault(ERR_DIGIT);
						fire = 1'b1;
					end else begin
						cnt = bump(cnt, 1);
						ph  = PH_INT;
					end
				end
				PH_INT, PH_FRAC, PH_EXP: begin
					b = (ph == PH_EXP) ? BASE_DEC : nb;
					if (c == CH_US || base_digit(b, c)) begin
						lus = (c == CH_US);
						cnt = bump(cnt, 1);
					end else if (ph == PH_INT) begin
						int_done = 1'b1;
					end else if (lus) begin
						r    = fault(ERR_USCORE);
						fire = 1'b1;
					end else if (ph == PH_FRAC && exp_letter(nb, c)) begin
						cnt = bump(cnt, 1);
						ph  = PH_EXP_START;
					end else if (nb == BASE_OCT || nb == BASE_BIN) begin
						r    = fault(ERR_BOFLT);
						fire = 1'b1;
					end else begin
						r    = pack_result(KIND_FLOAT, ERR_NONE, cnt, PB_TERM);
						fire = 1'b1;
					end
				end
				PH_DOT: begin
					// A dot counts only once a digit of the base follows it.
					if (base_digit(nb, c)) begin
						cnt = bump(cnt, 2);
						lus = 1'b0;
						ph  = PH_FRAC;
					end else begin
						r    = pack_result({1'b0, nb}, ERR_NONE, cnt, PB_DOT);
						fire = 1'b1;
					end
				end
				PH_EXP_START, PH_EXP_SIGN: begin
					if (ph == PH_EXP_START && (c == CH_PLUS || c == CH_MINUS)) begin
						cnt = bump(cnt, 1);
						ph  = PH_EXP_SIGN;
					end else if (!dec_digit(c)) begin
						r    = fault(ERR_DIGIT);
						fire = 1'b1;
					end else begin
						cnt = bump(cnt, 1);
						lus = 1'b0;
						ph  = PH_EXP;
					end
				end
				default: ph = PH_IDLE;
			endcase
		end
		// The character that ended the integer digit run.
		if (int_done) begin
			if (lus) begin
				r    = fault(ERR_USCORE);
				fire = 1'b1;
			end else if (c == CH_DOT) begin
				ph = PH_DOT;
			end else if (exp_letter(nb, c)) begin
				cnt = bump(cnt, 1);
				ph  = PH_EXP_START;
			end else begin
				r    = pack_result({1'b0, nb}, ERR_NONE, cnt, PB_TERM);
				fire = 1'b1;
			end
		end
		if (fire) begin
			ph = PH_IDLE;
			lit_results.insert(lit_results.size(), r);
		end
	endtask

	// Compare result words first, then take in the character word.
	always @(posedge clk or negedge arst_n) begin
		lit_result_t want;
		lit_result_t got;
		if (!arst_n) begin
			ph  = PH_IDLE;
			nb  = BASE_DEC;
			lus = 1'b0;
			cnt = 0;
			lit_results.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (lit_results.size() == 0) begin
					if (n_bad < 10) begin
						$display("%0t: result word with none expected: ", $realtime,
							"kind %0d error %0d length %0d pushback %0d",
							got.kind, got.error, got.length, got.pushback);
					end
					n_bad++;
				end else begin
					want = lit_results.pop_front();
					if (got.kind !== want.kind || got.error !== want.error ||
							got.length !== want.length || got.pushback !== want.pushback) begin
						if (n_bad < 10) begin
							$display("%0t: mismatch: expected ", $realtime,
								"kind %0d error %0d length %0d pushback %0d, ",
								want.kind, want.error, want.length, want.pushback,
								"got kind %0d error %0d length %0d pushback %0d",
								got.kind, got.error, got.length, got.pushback);
						end
						n_bad++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				lex_step(s_tdata, s_tuser[0]);
			end
		end
		n_wait = lit_results.size();
	end

endmodule

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb: testbench top for the numeric literal recognizer
// Drives character words into the lexer: a short directed set of corner
// literals, a hold-off on the output that fills the internal queue, then
// random literals in all bases with fractions, exponents, underscores,
// corruptions and noise. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import nlr_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic [7:0]  s_tdata = 8'h00;
	logic [0:0]  s_tuser = 1'b0;
	logic        m_tready = 1'b0;
	wire         s_tready;
	wire         m_tvalid;
	wire  [15:0] m_tdata;

	logic quiet = 1'b0;     // no idling on either side while set
	logic hold_req = 1'b0;  // asks the receiver for one long hold-off
	int   mismatches;
	int   pending;

	typedef struct {
		logic [7:0] c;
		logic       st;
	} src_word_t;

	src_word_t src_words[$];
	int        lit_chars = 0;
	logic      long_done = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	number_literal_recognizer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	nlr_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.mismatches (mismatches),
		.pending    (pending)
	);

	task automatic add_char(input logic [7:0] c, input logic st);
		src_word_t w;
		w.c  = c;
		w.st = st;
		src_words.insert(src_words.size(), w);
	endtask

	// A text whose first character starts a literal.
	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			add_char(s[i], i == 0);
		end
	endtask

	function automatic logic [7:0] pick_digit(base_t b);
		string hex_set = "0123456789abcdefABCDEF";
		case (b)
			BASE_HEX: return hex_set[$urandom_range(21)];
			BASE_OCT: return CH_0 + 8'($urandom_range(7));
			BASE_BIN: return CH_0 + 8'($urandom_range(1));
			default:  return CH_0 + 8'($urandom_range(9));
		endcase
	endfunction

	// Bytes with a random start flag; those arriving while idle are dropped.
	task automatic add_noise();
		repeat ($urandom_range(1, 4)) begin
			add_char(8'($urandom_range(255)), $urandom_range(3) == 0);
		end
	endtask

	// One mostly well-formed literal with random content.
	task automatic gen_literal();
		base_t      b;
		int         first_idx;
		int         span;
		int         k;
		logic [7:0] c;
		first_idx = src_words.size();
		b = base_t'($urandom_range(3));
		if (b == BASE_DEC) begin
			if ($urandom_range(5) == 0) begin
				add_char(CH_0, 1'b1);
			end else begin
				add_char(CH_1 + 8'($urandom_range(8)), 1'b1);
			end
		end else begin
			add_char(CH_0, 1'b1);
			case (b)
				BASE_HEX: c = $urandom_range(1) ? CH_LC_X : CH_UC_X;
				BASE_OCT: c = $urandom_range(1) ? CH_LC_O : CH_UC_O;
				default:  c = $urandom_range(1) ? CH_LC_B : CH_UC_B;
			endcase
			add_char(c, 1'b0);
			add_char(pick_digit(b), 1'b0);
		end
		repeat ($urandom_range(0, 6)) begin
			add_char(($urandom_range(99) < 15) ? CH_US : pick_digit(b), 1'b0);
		end
		// Fraction, sometimes a dot that is not followed by a digit.
		if ($urandom_range(99) < 30) begin
			add_char(CH_DOT, 1'b0);
			if ($urandom_range(9) == 0) begin
				add_char($urandom_range(1) ? CH_DOT : 8'($urandom_range(255)), 1'b0);
			end else begin
				repeat ($urandom_range(1, 4)) begin
					add_char(($urandom_range(99) < 10) ? CH_US : pick_digit(b), 1'b0);
				end
			end
		end
		// Exponent with an optional sign.
		if ((b == BASE_DEC || b == BASE_HEX) && $urandom_range(99) < 30) begin
			if (b == BASE_DEC) begin
				add_char($urandom_range(1) ? CH_LC_E : CH_UC_E, 1'b0);
			end else begin
				add_char($urandom_range(1) ? CH_LC_P : CH_UC_P, 1'b0);
			end
			k = $urandom_range(2);
			if (k == 1) begin
				add_char(CH_PLUS, 1'b0);
			end else if (k == 2) begin
				add_char(CH_MINUS, 1'b0);
			end
			repeat ($urandom_range(1, 3)) begin
				add_char(($urandom_range(99) < 10) ? CH_US : pick_digit(BASE_DEC), 1'b0);
			end
		end
		// Terminator; without one the next start abandons this literal.
		if ($urandom_range(9) != 0) begin
			case ($urandom_range(5))
				0:       add_char(8'h20, 1'b0);
				1:       add_char(8'h00, 1'b0);
				2:       add_char(8'h3b, 1'b0);
				3:       add_char(8'h2c, 1'b0);
				4:       add_char(8'h29, 1'b0);
				default: add_char(8'($urandom_range(255)), 1'b0);
			endcase
		end
		// Occasionally corrupt one character after the first.
		span = src_words.size() - first_idx;
		if ($urandom_range(99) < 12 && span > 1) begin
			src_words[first_idx + $urandom_range(1, span - 1)].c = 8'($urandom_range(255));
		end
		lit_chars += span;
	endtask

	// Offer the queued character words one by one, idling at random unless quiet is set.
	task automatic send_words();
		src_word_t w;
		while (src_words.size() > 0) begin
			w = src_words.pop_front();
			while (!quiet && $urandom_range(99) < 13) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
			s_tvalid <= 1'b1;
			s_tdata  <= w.c;
			s_tuser  <= w.st;
			do @(posedge clk); while (!s_tready);
		end
	endtask

	// Stop offering and hold until every predicted result has been taken.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
	endtask

	// Receiver: random stalls, one long hold-off counted here on request.
	initial begin
		int   hold_left;
		logic hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				hold_left = 80;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (quiet) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= ($urandom_range(99) >= 13);
			end
		end
	end

	initial begin
		#2_000_000;
		$display("tb failed");
		$finish;
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed corner literals.
		add_char(8'hff, 1'b0);        // byte while idle is dropped
		add_char(8'h61, 1'b1);        // bad first character
		add_text("05");               // redundant leading zero
		add_char(CH_1, 1'b1);         // start while busy abandons the first
		add_char(CH_1 + 8'd1, 1'b1);
		add_char(8'h00, 1'b0);        // end of line terminates
		add_text("0b1.0 ");           // binary float
		add_text("3..");              // lone dot gives two pushback
		add_text("1_ ");              // trailing underscore
		add_text("1e-5 ");            // decimal exponent with sign
		send_words();
		drain_results();

		// Hold off the receiver while short literals keep coming.
		hold_req <= 1'b1;
		quiet    <= 1'b1;
		repeat (30) begin
			add_char(CH_1 + 8'($urandom_range(8)), 1'b1);
			add_char(8'h20, 1'b0);
		end
		send_words();
		quiet <= 1'b0;
		drain_results();

		// Random literals and noise.
		while (lit_chars < 930) begin
			if ($urandom_range(99) < 15) begin
				add_noise();
			end else begin
				gen_literal();
			end
			send_words();
			if (!long_done && lit_chars > 400) begin
				// One literal past the length limit.
				long_done = 1'b1;
				add_char(CH_1, 1'b1);
				repeat (261) add_char(pick_digit(BASE_DEC), 1'b0);
				add_char(8'h20, 1'b0);
				lit_chars += 263;
				send_words();
				drain_results();
			end
			quiet <= (lit_chars > 700 && lit_chars < 900);
		end
		drain_results();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

endmodule

// ----- files.f -----
src/nlr_pkg.sv
src/nlr_front.sv
src/nlr_back.sv
src/number_literal_recognizer.sv
sim/nlr_checker.sv
sim/tb.sv
